[rtl/ita_pkg.sv]
package ita_pkg;

	localparam int unsigned COORD_BITS = 16;
	localparam int unsigned MAX_POINTS = 65536;
	localparam int unsigned SUM_BITS = 48;
	localparam int unsigned COUNT_BITS = 17;
	localparam int unsigned PROD_BITS = 2 * COORD_BITS;

	localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
	localparam int unsigned LIMIT_INT = (MAX_POINTS < COUNT_MAX) ? MAX_POINTS : COUNT_MAX;
	localparam logic [COUNT_BITS-1:0] POINT_LIMIT = COUNT_BITS'(LIMIT_INT);

	typedef struct packed {
		logic [PROD_BITS-1:0]        sq_x;
		logic [PROD_BITS-1:0]        sq_y;
		logic [PROD_BITS-1:0]        sq_z;
		logic signed [PROD_BITS-1:0] xy;
		logic signed [PROD_BITS-1:0] xz;
		logic signed [PROD_BITS-1:0] yz;
		logic                        last;
	} prod_t;

endpackage

[rtl/ita_products.sv]
module ita_products (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   point_valid,
	output logic                                   point_stall,
	input  logic signed [ita_pkg::COORD_BITS-1:0] x_coord,
	input  logic signed [ita_pkg::COORD_BITS-1:0] y_coord,
	input  logic signed [ita_pkg::COORD_BITS-1:0] z_coord,
	input  logic                                   last_point,
	output logic                                   prod_valid,
	output ita_pkg::prod_t                         prod_item,
	input  logic                                   prod_stall
);

	logic                                   v_s1;
	logic signed [ita_pkg::COORD_BITS-1:0] x_s1;
	logic signed [ita_pkg::COORD_BITS-1:0] y_s1;
	logic signed [ita_pkg::COORD_BITS-1:0] z_s1;
	logic                                   last_s1;
	logic                                   v_s2;
	ita_pkg::prod_t                         prod_s2;
	logic signed [ita_pkg::PROD_BITS-1:0]  sq_x;
	logic signed [ita_pkg::PROD_BITS-1:0]  sq_y;
	logic signed [ita_pkg::PROD_BITS-1:0]  sq_z;
	logic signed [ita_pkg::PROD_BITS-1:0]  p_xy;
	logic signed [ita_pkg::PROD_BITS-1:0]  p_xz;
	logic signed [ita_pkg::PROD_BITS-1:0]  p_yz;
	logic                                   rdy_s1;
	logic                                   rdy_s2;

	assign rdy_s2 = !v_s2 || !prod_stall;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign point_stall = !rdy_s1;

	assign sq_x = x_s1 * x_s1;
	assign sq_y = y_s1 * y_s1;
	assign sq_z = z_s1 * z_s1;
	assign p_xy = x_s1 * y_s1;
	assign p_xz = x_s1 * z_s1;
	assign p_yz = y_s1 * z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= point_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && point_valid) begin
			x_s1    <= x_coord;
			y_s1    <= y_coord;
			z_s1    <= z_coord;
			last_s1 <= last_point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			prod_s2.sq_x <= sq_x;
			prod_s2.sq_y <= sq_y;
			prod_s2.sq_z <= sq_z;
			prod_s2.xy   <= p_xy;
			prod_s2.xz   <= p_xz;
			prod_s2.yz   <= p_yz;
			prod_s2.last <= last_s1;
		end
	end

	assign prod_valid = v_s2;
	assign prod_item  = prod_s2;

`ifndef ASSERT_OFF
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> (v_s1 && v_s2 && prod_stall))
		else $error("input stalled while pipeline has room");
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && prod_stall) |=> (v_s2 && $stable(prod_s2)))
		else $error("product stage changed while stalled");
`endif

endmodule

[rtl/ita_accum.sv]
module ita_accum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 prod_valid,
	input  ita_pkg::prod_t                       prod_item,
	output logic                                 prod_stall,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [ita_pkg::SUM_BITS-1:0]        moment_xx,
	output logic [ita_pkg::SUM_BITS-1:0]        moment_yy,
	output logic [ita_pkg::SUM_BITS-1:0]        moment_zz,
	output logic signed [ita_pkg::SUM_BITS-1:0] product_xy,
	output logic signed [ita_pkg::SUM_BITS-1:0] product_xz,
	output logic signed [ita_pkg::SUM_BITS-1:0] product_yz,
	output logic [ita_pkg::COUNT_BITS-1:0]      point_count,
	output logic                                 overflow
);

	localparam int unsigned SB = ita_pkg::SUM_BITS;
	localparam int unsigned PB = ita_pkg::PROD_BITS;
	localparam int unsigned CB = ita_pkg::COUNT_BITS;

	logic [SB-1:0]          diag_q [3];
	logic signed [SB-1:0]   cross_q [3];
	logic [CB-1:0]          count_q;
	logic                   sat_q;
	logic [PB:0]            dadd [3];
	logic signed [PB:0]     cadd [3];
	logic [SB:0]            dsum [3];
	logic [SB:0]            csum [3];
	logic [SB-1:0]          diag_nx [3];
	logic signed [SB-1:0]   cross_nx [3];
	logic [CB-1:0]          count_nx;
	logic                   sat_nx;
	logic                   drop;
	logic                   take;
	logic                   res_valid_q;
	logic [SB-1:0]          res_diag_q [3];
	logic signed [SB-1:0]   res_cross_q [3];
	logic [CB-1:0]          res_count_q;
	logic                   res_sat_q;

	assign prod_stall = prod_item.last && res_valid_q && result_stall;
	assign take = prod_valid && !prod_stall;
	assign drop = count_q >= ita_pkg::POINT_LIMIT;

	always_comb begin
		dadd[0] = {1'b0, prod_item.sq_y} + {1'b0, prod_item.sq_z};
		dadd[1] = {1'b0, prod_item.sq_x} + {1'b0, prod_item.sq_z};
		dadd[2] = {1'b0, prod_item.sq_x} + {1'b0, prod_item.sq_y};
		cadd[0] = -((PB+1)'(prod_item.xy));
		cadd[1] = -((PB+1)'(prod_item.xz));
		cadd[2] = -((PB+1)'(prod_item.yz));
		sat_nx = sat_q || drop;
		count_nx = drop ? count_q : count_q + CB'(1);
		for (int i = 0; i < 3; i++) begin
			dsum[i] = {1'b0, diag_q[i]} + (SB+1)'(dadd[i]);
			csum[i] = {cross_q[i][SB-1], cross_q[i]} + (SB+1)'(cadd[i]);
			diag_nx[i] = diag_q[i];
			cross_nx[i] = cross_q[i];
			if (!drop) begin
				if (dsum[i][SB]) begin
					diag_nx[i] = {SB{1'b1}};
					sat_nx = 1'b1;
				end else begin
					diag_nx[i] = dsum[i][SB-1:0];
				end
				if (csum[i][SB] != csum[i][SB-1]) begin
					cross_nx[i] = csum[i][SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
					sat_nx = 1'b1;
				end else begin
					cross_nx[i] = csum[i][SB-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				diag_q[i]  <= '0;
				cross_q[i] <= '0;
			end
			count_q <= '0;
			sat_q   <= 1'b0;
		end else if (take) begin
			if (prod_item.last) begin
				for (int i = 0; i < 3; i++) begin
					diag_q[i]  <= '0;
					cross_q[i] <= '0;
				end
				count_q <= '0;
				sat_q   <= 1'b0;
			end else begin
				diag_q  <= diag_nx;
				cross_q <= cross_nx;
				count_q <= count_nx;
				sat_q   <= sat_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && prod_item.last) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && prod_item.last) begin
			res_diag_q  <= diag_nx;
			res_cross_q <= cross_nx;
			res_count_q <= count_nx;
			res_sat_q   <= sat_nx;
		end
	end

	assign result_valid = res_valid_q;
	assign moment_xx    = res_diag_q[0];
	assign moment_yy    = res_diag_q[1];
	assign moment_zz    = res_diag_q[2];
	assign product_xy   = res_cross_q[0];
	assign product_xz   = res_cross_q[1];
	assign product_yz   = res_cross_q[2];
	assign point_count  = res_count_q;
	assign overflow     = res_sat_q;

`ifndef ASSERT_OFF
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && prod_item.last) |=> result_valid)
		else $error("last transaction produced no result");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && prod_item.last) |=> (count_q == '0 && !sat_q))
		else $error("sums not cleared after last transaction");
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ita_pkg::POINT_LIMIT)
		else $error("point count beyond limit");
	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (point_count != '0))
		else $error("result with zero point count");
`endif

endmodule

[rtl/inertia_tensor_accumulator.sv]
// Accumulates the inertia tensor of a stream of unit-mass points. Each point
// transaction carries signed x, y and z; one point is taken every clock while
// the input is not stalled. After a set's last point is taken, it passes the
// input register, then the product register, then the accumulator/result
// register, which holds the result. The six squares and cross products are
// formed in parallel, one multiplier each, and the sums update once per cycle
// while a product is taken. The input stalls only when a last point reaches
// the accumulator while the previous result is still held stalled.
// Points beyond the point limit are dropped and set overflow; sums clamp.
module inertia_tensor_accumulator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 point_valid,
	output logic                                 point_stall,
	input  logic signed [ita_pkg::COORD_BITS-1:0] x_coord,
	input  logic signed [ita_pkg::COORD_BITS-1:0] y_coord,
	input  logic signed [ita_pkg::COORD_BITS-1:0] z_coord,
	input  logic                                 last_point,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [ita_pkg::SUM_BITS-1:0]        moment_xx,
	output logic [ita_pkg::SUM_BITS-1:0]        moment_yy,
	output logic [ita_pkg::SUM_BITS-1:0]        moment_zz,
	output logic signed [ita_pkg::SUM_BITS-1:0] product_xy,
	output logic signed [ita_pkg::SUM_BITS-1:0] product_xz,
	output logic signed [ita_pkg::SUM_BITS-1:0] product_yz,
	output logic [ita_pkg::COUNT_BITS-1:0]      point_count,
	output logic                                 overflow
);

	logic           prod_valid;
	logic           prod_stall;
	ita_pkg::prod_t prod_item;

	ita_products u_products (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.z_coord     (z_coord),
		.last_point  (last_point),
		.prod_valid  (prod_valid),
		.prod_item   (prod_item),
		.prod_stall  (prod_stall)
	);

	ita_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.prod_valid   (prod_valid),
		.prod_item    (prod_item),
		.prod_stall   (prod_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.moment_xx    (moment_xx),
		.moment_yy    (moment_yy),
		.moment_zz    (moment_zz),
		.product_xy   (product_xy),
		.product_xz   (product_xz),
		.product_yz   (product_yz),
		.point_count  (point_count),
		.overflow     (overflow)
	);

endmodule

[sim/inertia_tensor_accumulator_test.sv]
`timescale 1ns / 1ps

module inertia_tensor_accumulator_test;

	localparam int unsigned CB = ita_pkg::COORD_BITS;
	localparam int unsigned SB = ita_pkg::SUM_BITS;
	localparam int unsigned NB = ita_pkg::COUNT_BITS;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned RANDOM_POINTS = 1080;
	localparam longint DIAG_TOP = (longint'(1) << SB) - 1;
	localparam longint CROSS_HI = (longint'(1) << (SB - 1)) - 1;
	localparam longint CROSS_LO = -CROSS_HI - 1;

	typedef logic signed [CB-1:0] coord_t;

	localparam coord_t COORD_MIN = {1'b1, {(CB - 1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(CB - 1){1'b1}}};

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   last;
	} point_t;

	typedef struct packed {
		logic [SB-1:0]        xx;
		logic [SB-1:0]        yy;
		logic [SB-1:0]        zz;
		logic signed [SB-1:0] xy;
		logic signed [SB-1:0] xz;
		logic signed [SB-1:0] yz;
		logic [NB-1:0]        count;
		logic                 ovf;
	} tensor_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   point_valid = 1'b0;
	logic   point_stall;
	coord_t x_coord = '0;
	coord_t y_coord = '0;
	coord_t z_coord = '0;
	logic   last_point = 1'b0;
	logic   result_valid;
	logic   result_stall = 1'b0;
	logic [SB-1:0]        moment_xx;
	logic [SB-1:0]        moment_yy;
	logic [SB-1:0]        moment_zz;
	logic signed [SB-1:0] product_xy;
	logic signed [SB-1:0] product_xz;
	logic signed [SB-1:0] product_yz;
	logic [NB-1:0]        point_count;
	logic                 overflow;

	point_t  pending_points[$];
	tensor_t expected_tensors[$];

	longint      diag_acc[3];
	longint      cross_acc[3];
	int unsigned points_acc = 0;
	logic        sums_saturated = 1'b0;

	int unsigned points_taken = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned send_gap = 0;
	int unsigned send_calm = 0;
	int unsigned stall_left = 0;
	int unsigned recv_calm = 0;
	int unsigned hold_left = 0;
	int unsigned holds_done = 0;
	point_t      next_point;
	tensor_t     seen_tensor;
	tensor_t     want_tensor;

	inertia_tensor_accumulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.z_coord(z_coord),
		.last_point(last_point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.moment_xx(moment_xx),
		.moment_yy(moment_yy),
		.moment_zz(moment_zz),
		.product_xy(product_xy),
		.product_xz(product_xz),
		.product_yz(product_yz),
		.point_count(point_count),
		.overflow(overflow)
	);

	always #5 clk = ~clk;

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return coord_t'(int'($urandom_range(0, 16)) - 8);
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic longint clamp_sum(longint s, longint lo, longint hi);
		if (s > hi) begin
			sums_saturated = 1'b1;
			return hi;
		end
		if (s < lo) begin
			sums_saturated = 1'b1;
			return lo;
		end
		return s;
	endfunction

	task automatic clear_tensor();
		for (int i = 0; i < 3; i++) begin
			diag_acc[i] = 0;
			cross_acc[i] = 0;
		end
		points_acc = 0;
		sums_saturated = 1'b0;
	endtask

	task automatic accumulate_point(input point_t p);
		longint x, y, z;
		tensor_t t;
		x = p.x;
		y = p.y;
		z = p.z;
		if (points_acc >= ita_pkg::LIMIT_INT) begin
			sums_saturated = 1'b1;
		end else begin
			diag_acc[0] = clamp_sum(diag_acc[0] + y * y + z * z, 0, DIAG_TOP);
			diag_acc[1] = clamp_sum(diag_acc[1] + x * x + z * z, 0, DIAG_TOP);
			diag_acc[2] = clamp_sum(diag_acc[2] + x * x + y * y, 0, DIAG_TOP);
			cross_acc[0] = clamp_sum(cross_acc[0] - x * y, CROSS_LO, CROSS_HI);
			cross_acc[1] = clamp_sum(cross_acc[1] - x * z, CROSS_LO, CROSS_HI);
			cross_acc[2] = clamp_sum(cross_acc[2] - y * z, CROSS_LO, CROSS_HI);
			points_acc++;
		end
		if (p.last) begin
			t.xx = diag_acc[0][SB-1:0];
			t.yy = diag_acc[1][SB-1:0];
			t.zz = diag_acc[2][SB-1:0];
			t.xy = cross_acc[0][SB-1:0];
			t.xz = cross_acc[1][SB-1:0];
			t.yz = cross_acc[2][SB-1:0];
			t.count = points_acc[NB-1:0];
			t.ovf = sums_saturated;
			expected_tensors.push_back(t);
			clear_tensor();
		end
	endtask

	task automatic add_point(input coord_t x, input coord_t y, input coord_t z, input logic last);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		p.last = last;
		pending_points.push_back(p);
	endtask

	// point driver and input-side predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid <= 1'b0;
		end else begin
			if (point_valid && !point_stall) begin
				accumulate_point('{x_coord, y_coord, z_coord, last_point});
				points_taken <= points_taken + 1;
			end
			if (!point_valid || !point_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					point_valid <= 1'b0;
				end else if (pending_points.size() != 0) begin
					next_point = pending_points.pop_front();
					x_coord <= next_point.x;
					y_coord <= next_point.y;
					z_coord <= next_point.z;
					last_point <= next_point.last;
					point_valid <= 1'b1;
					if (send_calm != 0) begin
						send_calm <= send_calm - 1;
						send_gap <= 0;
					end else if ($urandom_range(0, 63) == 0) begin
						send_calm <= $urandom_range(20, 150);
						send_gap <= 0;
					end else begin
						send_gap <= gap_len();
					end
				end else begin
					point_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold so the pipeline backs up into the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && points_taken >= (holds_done == 0 ? 300 : 800)) begin
			hold_left <= 400;
			holds_done <= holds_done + 1;
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				seen_tensor = '{moment_xx, moment_yy, moment_zz, product_xy, product_xz,
					product_yz, point_count, overflow};
				if (expected_tensors.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transaction: xx=%0d count=%0d",
							moment_xx, point_count);
				end else begin
					want_tensor = expected_tensors.pop_front();
					if (seen_tensor !== want_tensor) begin
						errors++;
						if (errors <= 10) begin
							$display("expected: %0d %0d %0d %0d %0d %0d n=%0d ovf=%0d",
								want_tensor.xx, want_tensor.yy, want_tensor.zz, want_tensor.xy,
								want_tensor.xz, want_tensor.yz, want_tensor.count, want_tensor.ovf);
							$display("actual:   %0d %0d %0d %0d %0d %0d n=%0d ovf=%0d",
								seen_tensor.xx, seen_tensor.yy, seen_tensor.zz, seen_tensor.xy,
								seen_tensor.xz, seen_tensor.yz, seen_tensor.count, seen_tensor.ovf);
						end
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= (hold_left != 0);
				if (recv_calm != 0)
					recv_calm <= recv_calm - 1;
				else if ($urandom_range(0, 63) == 0)
					recv_calm <= $urandom_range(20, 120);
				else
					stall_left <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** inertia_tensor_accumulator: FAILED **");
			$finish;
		end
	end

	initial begin
		int unsigned random_points;
		int unsigned set_len;

		clear_tensor();

		// extremes and sign patterns, single and multi point sets
		add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
		add_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		add_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
		add_point(COORD_MIN, COORD_MAX, coord_t'(0), 1'b1);
		add_point(COORD_MAX, COORD_MIN, coord_t'(1), 1'b0);
		add_point(coord_t'(-1), coord_t'(-1), coord_t'(-1), 1'b0);
		add_point(COORD_MIN, coord_t'(0), COORD_MAX, 1'b1);
		add_point(coord_t'(1), coord_t'(2), coord_t'(3), 1'b0);
		add_point(coord_t'(-4), coord_t'(5), coord_t'(-6), 1'b0);
		add_point(coord_t'(7), coord_t'(-8), coord_t'(9), 1'b0);
		add_point(coord_t'(16'h5555), coord_t'(16'haaaa), coord_t'(16'h5555), 1'b1);
		add_point(coord_t'(12345), coord_t'(-23456), coord_t'(31000), 1'b1);
		add_point(coord_t'(-1), coord_t'(1), coord_t'(-1), 1'b1);

		random_points = 0;
		while (random_points < RANDOM_POINTS) begin
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			for (int i = 0; i < set_len; i++)
				add_point(rand_coord(), rand_coord(), rand_coord(), i == set_len - 1);
			random_points += set_len;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_points.size() != 0 || point_valid)
			@(posedge clk);
		while (expected_tensors.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("** inertia_tensor_accumulator: PASSED **");
		else
			$display("** inertia_tensor_accumulator: FAILED **");
		$finish;
	end

endmodule
